// ===== rtl/nlt_pkg.sv =====
package nlt_pkg;

    // table geometry
    localparam int NODE_SLOTS   = 16;
    localparam int HOLDER_DEPTH = 8;
    localparam int WAIT_DEPTH   = 8;
    localparam int MODE_COUNT   = 4;

    // derived widths
    localparam int SLOT_W  = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
    localparam int HIDX_W  = (HOLDER_DEPTH > 1) ? $clog2(HOLDER_DEPTH) : 1;
    localparam int WIDX_W  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int CNT_W   = $clog2(WAIT_DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int HENT    = NODE_SLOTS * HOLDER_DEPTH;
    localparam int WENT    = NODE_SLOTS * WAIT_DEPTH;
    localparam int HAW     = (HENT > 1) ? $clog2(HENT) : 1;
    localparam int WAW     = (WENT > 1) ? $clog2(WENT) : 1;
    localparam int ENTRY_W = 10;

    localparam logic [15:0] CFG_RESET = 16'd50;

    localparam logic OP_LOCK   = 1'b0;
    localparam logic OP_UNLOCK = 1'b1;

    typedef enum logic [2:0] {
        KIND_GRANT    = 3'd0,
        KIND_QUEUED   = 3'd1,
        KIND_WOKEN    = 3'd2,
        KIND_UNLOCKED = 3'd3,
        KIND_ERROR    = 3'd4
    } kind_t;

    typedef struct packed {
        logic  latch;
        logic  lookup;
        logic  alloc;
        logic  scan_start;
        logic  enqueue;
        logic  grant;
        logic  release_h;
        logic  wake_read;
        logic  wake_take;
        logic  queue_update;
        logic  slot_check;
        logic  emit_direct;
        kind_t direct_kind;
        logic  pend_unlock;
        logic  flush_last;
    } cmd_t;

    typedef struct packed {
        logic mode_bad;
        logic slot_hit;
        logic slot_avail;
        logic is_unlock;
        logic scan_done;
        logic found;
        logic clash_req;
        logic count_zero;
        logic wait_full;
        logic holder_avail;
        logic wake_more;
        logic wake_ok;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/node_lock_table_with_wait_queues.sv =====
// lock request: result loaded after lookup, a holder scan of HOLDER_DEPTH reads from the
//   registered read port, decide and output register; bad mode or no slot skip the scan
// unlock: earlier results go out as each waiter is woken; the last is loaded after the
//   queue update, once the wake loop meets no waiter left or a waiter that stays queued
// one request at a time; next beat taken the cycle after the last result is loaded;
//   a stalled output holds the controller until taken
// reset (async, active low): all slots free, holders invalid, queues empty,
//   conflict matrix shared/exclusive; no clearing pass
module node_lock_table_with_wait_queues (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // node_id[15:0], txn_id[23:16], lock_mode[25:24]
    input  logic        s_axis_tuser,   // op: 0 lock, 1 unlock
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_txn[7:0], out_node[23:8]
    output logic [2:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    import nlt_pkg::*;

    cmd_t        cmd;
    status_t     status;
    logic [7:0]  out_txn;
    logic [15:0] out_node;

    assign cfg_ready = 1'b1;

    nlt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    nlt_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_mode   (s_axis_tuser),
        .in_node   (s_axis_tdata[15:0]),
        .in_txn    (s_axis_tdata[23:16]),
        .in_lm     (s_axis_tdata[25:24]),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_wdata (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_kind  (m_axis_tuser),
        .out_txn   (out_txn),
        .out_node  (out_node),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {out_node, out_txn};

    // checks on controller decisions
    a_grant_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.grant |-> status.holder_avail)
        else $error("grant without a free holder entry");

    a_enqueue_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.enqueue |-> !status.wait_full)
        else $error("enqueue into a full wait queue");

    a_wake_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wake_take |-> status.out_free)
        else $error("wake-up overwrites a waiting result");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second beat taken while a request is in work");

endmodule

// ===== rtl/nlt_ram.sv =====
module nlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/nlt_dp.sv =====
module nlt_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_mode,
    input  logic [15:0]         in_node,
    input  logic [7:0]          in_txn,
    input  logic [1:0]          in_lm,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    input  nlt_pkg::cmd_t       cmd,
    output nlt_pkg::status_t    status,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [2:0]          out_kind,
    output logic [7:0]          out_txn,
    output logic [15:0]         out_node,
    output logic                out_last
);

    import nlt_pkg::*;

    function automatic logic [HAW-1:0] h_addr(logic [SLOT_W-1:0] s, logic [HIDX_W-1:0] e);
        return HAW'(s) * HAW'(HOLDER_DEPTH) + HAW'(e);
    endfunction

    function automatic logic [WAW-1:0] w_addr(logic [SLOT_W-1:0] s, logic [WIDX_W-1:0] e);
        return WAW'(s) * WAW'(WAIT_DEPTH) + WAW'(e);
    endfunction

    // circular queue position, offset stays at or below the depth
    function automatic logic [WIDX_W-1:0] wq_index(logic [WIDX_W-1:0] head,
                                                   logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(off);
        if (sum >= SUM_W'(WAIT_DEPTH))
        begin
            sum = sum - SUM_W'(WAIT_DEPTH);
        end
        return WIDX_W'(sum);
    endfunction

    function automatic logic [MODE_COUNT-1:0] mode_bit(logic [1:0] m);
        logic [MODE_COUNT-1:0] r;
        r = '0;
        for (int i = 0; i < MODE_COUNT; i++)
        begin
            if (m == 2'(i))
            begin
                r[i] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic clash(logic [MODE_COUNT-1:0] mask, logic [1:0] req,
                                   logic [15:0] matrix);
        logic r;
        r = 1'b0;
        for (int i = 0; i < MODE_COUNT; i++)
        begin
            if (mask[i] && matrix[{2'(i), req}])
            begin
                r = 1'b1;
            end
        end
        return r;
    endfunction

    logic [15:0]              cfg_reg;
    logic                     req_op_reg;
    logic [15:0]              req_node_reg;
    logic [7:0]               req_txn_reg;
    logic [1:0]               req_lm_reg;
    logic [SLOT_W-1:0]        slot_reg;

    logic                     slot_valid_reg [NODE_SLOTS];
    logic [15:0]              slot_node_reg  [NODE_SLOTS];
    logic [CNT_W-1:0]         wcount_reg     [NODE_SLOTS];
    logic [WIDX_W-1:0]        whead_reg      [NODE_SLOTS];
    logic [HOLDER_DEPTH-1:0]  hvalid_reg     [NODE_SLOTS];

    logic                     scanning_reg;
    logic [HIDX_W-1:0]        rd_idx_reg;
    logic                     ev_valid_reg;
    logic [HIDX_W-1:0]        ev_idx_reg;
    logic [MODE_COUNT-1:0]    mask_reg;
    logic                     found_reg;
    logic [HIDX_W-1:0]        hidx_reg;
    logic [CNT_W-1:0]         wake_i_reg;

    logic                     out_valid_reg;
    kind_t                    out_kind_reg;
    logic [7:0]               out_txn_reg;
    logic [15:0]              out_node_reg;
    logic                     out_last_reg;
    kind_t                    pend_kind_reg;
    logic [7:0]               pend_txn_reg;

    logic                     hit;
    logic [SLOT_W-1:0]        hit_idx;
    logic                     avail;
    logic [SLOT_W-1:0]        free_idx;
    logic [HOLDER_DEPTH-1:0]  slot_hv;
    logic                     free_h_avail;
    logic [HIDX_W-1:0]        free_h;
    logic [CNT_W-1:0]         cur_count;
    logic [WIDX_W-1:0]        cur_head;
    logic                     ev_hv;
    logic [ENTRY_W-1:0]       h_rdata;
    logic [ENTRY_W-1:0]       w_rdata;
    logic                     h_we;
    logic [HAW-1:0]           h_waddr;
    logic [ENTRY_W-1:0]       h_wdata;
    logic                     out_free;

    // node lookup, lowest matching and lowest free slot
    always_comb
    begin
        hit      = 1'b0;
        hit_idx  = '0;
        avail    = 1'b0;
        free_idx = '0;
        for (int s = NODE_SLOTS - 1; s >= 0; s--)
        begin
            if (slot_valid_reg[s] && slot_node_reg[s] == req_node_reg)
            begin
                hit     = 1'b1;
                hit_idx = SLOT_W'(s);
            end
            if (!slot_valid_reg[s])
            begin
                avail    = 1'b1;
                free_idx = SLOT_W'(s);
            end
        end
    end

    // current slot view and lowest free holder
    assign slot_hv = hvalid_reg[slot_reg];

    always_comb
    begin
        free_h_avail = 1'b0;
        free_h       = '0;
        for (int e = HOLDER_DEPTH - 1; e >= 0; e--)
        begin
            if (!slot_hv[e])
            begin
                free_h_avail = 1'b1;
                free_h       = HIDX_W'(e);
            end
        end
    end

    assign cur_count = wcount_reg[slot_reg];
    assign cur_head  = whead_reg[slot_reg];
    assign ev_hv     = slot_hv[ev_idx_reg];
    assign out_free  = !out_valid_reg || out_ready;

    // holder entry store: txn and mode
    assign h_we    = cmd.grant || cmd.wake_take;
    assign h_waddr = h_addr(slot_reg, free_h);
    assign h_wdata = cmd.wake_take ? w_rdata : {req_txn_reg, req_lm_reg};

    nlt_ram #(.WIDTH(ENTRY_W), .DEPTH(HENT)) u_holder_ram (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .re    (scanning_reg),
        .raddr (h_addr(slot_reg, rd_idx_reg)),
        .rdata (h_rdata)
    );

    // waiter fifo store
    nlt_ram #(.WIDTH(ENTRY_W), .DEPTH(WENT)) u_waiter_ram (
        .clk   (clk),
        .we    (cmd.enqueue),
        .waddr (w_addr(slot_reg, wq_index(cur_head, cur_count))),
        .wdata ({req_txn_reg, req_lm_reg}),
        .re    (cmd.wake_read),
        .raddr (w_addr(slot_reg, wq_index(cur_head, wake_i_reg))),
        .rdata (w_rdata)
    );

    // status to controller
    always_comb
    begin
        status.mode_bad     = {1'b0, req_lm_reg} >= 3'(MODE_COUNT);
        status.slot_hit     = hit;
        status.slot_avail   = avail;
        status.is_unlock    = (req_op_reg == OP_UNLOCK);
        status.scan_done    = ev_valid_reg && (ev_idx_reg == HIDX_W'(HOLDER_DEPTH - 1));
        status.found        = found_reg;
        status.clash_req    = clash(mask_reg, req_lm_reg, cfg_reg);
        status.count_zero   = (cur_count == '0);
        status.wait_full    = (cur_count >= CNT_W'(WAIT_DEPTH));
        status.holder_avail = free_h_avail;
        status.wake_more    = (wake_i_reg < cur_count);
        status.wake_ok      = !clash(mask_reg, w_rdata[1:0], cfg_reg) && free_h_avail;
        status.out_free     = out_free;
    end

    // config register and request capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            cfg_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_op_reg   <= in_mode;
            req_node_reg <= in_node;
            req_txn_reg  <= in_txn;
            req_lm_reg   <= in_lm;
        end
        if (cmd.lookup)
        begin
            slot_reg <= hit ? hit_idx : free_idx;
        end
        if (cmd.alloc)
        begin
            slot_node_reg[free_idx] <= req_node_reg;
        end
    end

    // slot table, fifo counters and holder valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NODE_SLOTS; s++)
            begin
                slot_valid_reg[s] <= 1'b0;
                wcount_reg[s]     <= '0;
                whead_reg[s]      <= '0;
                hvalid_reg[s]     <= '0;
            end
        end
        else
        begin
            if (cmd.alloc)
            begin
                slot_valid_reg[free_idx] <= 1'b1;
                wcount_reg[free_idx]     <= '0;
                whead_reg[free_idx]      <= '0;
                hvalid_reg[free_idx]     <= '0;
            end
            if (cmd.grant || cmd.wake_take)
            begin
                hvalid_reg[slot_reg][free_h] <= 1'b1;
            end
            if (cmd.release_h)
            begin
                hvalid_reg[slot_reg][hidx_reg] <= 1'b0;
            end
            if (cmd.enqueue)
            begin
                wcount_reg[slot_reg] <= cur_count + CNT_W'(1);
            end
            if (cmd.queue_update)
            begin
                wcount_reg[slot_reg] <= cur_count - wake_i_reg;
                whead_reg[slot_reg]  <= wq_index(cur_head, wake_i_reg);
            end
            if (cmd.slot_check && cur_count == '0 && slot_hv == '0)
            begin
                slot_valid_reg[slot_reg] <= 1'b0;
            end
        end
    end

    // holder scan: one read issued per cycle, evaluated in the cycle after it is issued
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scanning_reg <= 1'b0;
            ev_valid_reg <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            scanning_reg <= 1'b1;
            ev_valid_reg <= 1'b0;
        end
        else
        begin
            ev_valid_reg <= scanning_reg;
            if (scanning_reg && rd_idx_reg == HIDX_W'(HOLDER_DEPTH - 1))
            begin
                scanning_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            rd_idx_reg <= '0;
            mask_reg   <= '0;
            found_reg  <= 1'b0;
            wake_i_reg <= '0;
        end
        else
        begin
            ev_idx_reg <= rd_idx_reg;
            if (scanning_reg)
            begin
                rd_idx_reg <= rd_idx_reg + HIDX_W'(1);
            end
            if (ev_valid_reg && ev_hv)
            begin
                if (req_op_reg == OP_UNLOCK && !found_reg && h_rdata[9:2] == req_txn_reg)
                begin
                    found_reg <= 1'b1;
                    hidx_reg  <= ev_idx_reg;
                end
                else
                begin
                    mask_reg <= mask_reg | mode_bit(h_rdata[1:0]);
                end
            end
            if (cmd.wake_take)
            begin
                mask_reg   <= mask_reg | mode_bit(w_rdata[1:0]);
                wake_i_reg <= wake_i_reg + CNT_W'(1);
            end
        end
    end

    // output register and pending result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_direct || cmd.wake_take || cmd.flush_last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_direct)
        begin
            out_kind_reg <= cmd.direct_kind;
            out_txn_reg  <= req_txn_reg;
            out_node_reg <= req_node_reg;
            out_last_reg <= 1'b1;
        end
        else if (cmd.wake_take || cmd.flush_last)
        begin
            out_kind_reg <= pend_kind_reg;
            out_txn_reg  <= pend_txn_reg;
            out_node_reg <= req_node_reg;
            out_last_reg <= cmd.flush_last;
        end
        if (cmd.pend_unlock)
        begin
            pend_kind_reg <= KIND_UNLOCKED;
            pend_txn_reg  <= req_txn_reg;
        end
        else if (cmd.wake_take)
        begin
            pend_kind_reg <= KIND_WOKEN;
            pend_txn_reg  <= w_rdata[9:2];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_txn   = out_txn_reg;
    assign out_node  = out_node_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== rtl/nlt_ctrl.sv =====
module nlt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  nlt_pkg::status_t  status,
    output nlt_pkg::cmd_t     cmd
);

    import nlt_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SCAN,
        ST_DECIDE,
        ST_RESULT,
        ST_WREQ,
        ST_WEVAL,
        ST_WFIN,
        ST_FLUSH
    } state_t;

    state_t state_reg, state_next;
    kind_t  res_kind_reg, res_kind_next;

    // state and result kind
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            res_kind_reg <= KIND_GRANT;
        end
        else
        begin
            state_reg    <= state_next;
            res_kind_reg <= res_kind_next;
        end
    end

    // sequencing
    always_comb
    begin
        cmd             = '0;
        cmd.direct_kind = res_kind_reg;
        state_next      = state_reg;
        res_kind_next   = res_kind_reg;
        in_ready        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (!status.is_unlock && status.mode_bad)
                begin
                    res_kind_next = KIND_ERROR;
                    state_next    = ST_RESULT;
                end
                else if (status.slot_hit)
                begin
                    cmd.lookup     = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
                else if (!status.is_unlock && status.slot_avail)
                begin
                    cmd.lookup     = 1'b1;
                    cmd.alloc      = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
                else
                begin
                    res_kind_next = KIND_ERROR;
                    state_next    = ST_RESULT;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (status.is_unlock)
                begin
                    if (status.found)
                    begin
                        cmd.release_h   = 1'b1;
                        cmd.pend_unlock = 1'b1;
                        state_next      = ST_WREQ;
                    end
                    else
                    begin
                        res_kind_next = KIND_ERROR;
                        state_next    = ST_RESULT;
                    end
                end
                else if (!status.count_zero || status.clash_req)
                begin
                    if (status.wait_full)
                    begin
                        res_kind_next = KIND_ERROR;
                    end
                    else
                    begin
                        cmd.enqueue   = 1'b1;
                        res_kind_next = KIND_QUEUED;
                    end
                    state_next = ST_RESULT;
                end
                else
                begin
                    if (status.holder_avail)
                    begin
                        cmd.grant     = 1'b1;
                        res_kind_next = KIND_GRANT;
                    end
                    else
                    begin
                        res_kind_next = KIND_ERROR;
                    end
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_direct = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_WREQ:
            begin
                if (status.wake_more)
                begin
                    cmd.wake_read = 1'b1;
                    state_next    = ST_WEVAL;
                end
                else
                begin
                    state_next = ST_WFIN;
                end
            end
            ST_WEVAL:
            begin
                if (!status.wake_ok)
                begin
                    state_next = ST_WFIN;
                end
                else if (status.out_free)
                begin
                    cmd.wake_take = 1'b1;
                    state_next    = ST_WREQ;
                end
            end
            ST_WFIN:
            begin
                cmd.queue_update = 1'b1;
                state_next       = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                if (status.out_free)
                begin
                    cmd.slot_check = 1'b1;
                    cmd.flush_last = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
